>>> design/csvt_pkg.sv
package csvt_pkg;

   localparam int MAX_FIELDS = 32;
   localparam int COL_W      = 5;
   localparam logic [COL_W-1:0] COL_CAP =
      ((MAX_FIELDS - 1) < 31) ? COL_W'(MAX_FIELDS - 1) : COL_W'(31);

   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] SEP_RESET   = 8'd44;
   localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'd34;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEP   = 1'b0,
      CSR_QUOTE = 1'b1
   } csr_idx_type;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic [COL_W-1:0]  field_index;
      logic              field_end;
      logic              record_end;
      logic              quote_error;
   } result_type;

   // r0 always holds a result; r1 only when two is set
   typedef struct packed {
      result_type r0;
      result_type r1;
      logic       two;
   } entry_type;

endpackage

>>> design/csvt_front.sv
module csvt_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [csvt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csvt_pkg::BYTE_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [csvt_pkg::BYTE_W-1:0]     req_in_byte,
   input  logic                            req_line_last,
   input  logic                            q_full,
   output logic                            q_push,
   output csvt_pkg::entry_type             q_entry
);

   typedef enum logic [5:0] {
      STATE_START = 6'b000001,
      STATE_UNQ   = 6'b000010,
      STATE_UNQ_Q = 6'b000100,
      STATE_QUO   = 6'b001000,
      STATE_QUO_Q = 6'b010000,
      STATE_AFTER = 6'b100000
   } parse_state_type;

   logic [csvt_pkg::BYTE_W-1:0] sep_ff, sep_in;
   logic [csvt_pkg::BYTE_W-1:0] quote_ff, quote_in;
   parse_state_type             state_ff, state_in, state_mid;
   logic [csvt_pkg::COL_W-1:0]  col_ff, col_in, col_mid;
   logic                        accept, is_sep, is_quo, act_byte, act_end;
   csvt_pkg::result_type        act_res, line_res;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sep_in   = sep_ff;
      quote_in = quote_ff;
      if (csr_we) begin
         case (csvt_pkg::csr_idx_type'(csr_index))
            csvt_pkg::CSR_SEP:   sep_in   = csr_wdata;
            csvt_pkg::CSR_QUOTE: quote_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign is_sep = (req_in_byte == sep_ff);
   assign is_quo = (req_in_byte == quote_ff) && !is_sep;

   always_comb begin
      state_mid = state_ff;
      act_byte  = 1'b0;
      act_end   = 1'b0;
      case (state_ff)
         STATE_UNQ: begin
            if (is_sep) begin
               act_end = 1'b1;
            end else begin
               act_byte = 1'b1;
               if (is_quo) state_mid = STATE_UNQ_Q;
            end
         end
         STATE_UNQ_Q: begin
            if (is_sep) begin
               act_end = 1'b1;
            end else if (is_quo) begin
               state_mid = STATE_UNQ;
            end else begin
               act_byte  = 1'b1;
               state_mid = STATE_UNQ;
            end
         end
         STATE_QUO: begin
            if (is_quo) state_mid = STATE_QUO_Q;
            else        act_byte  = 1'b1;
         end
         STATE_QUO_Q: begin
            if (is_quo) begin
               act_byte  = 1'b1;
               state_mid = STATE_QUO;
            end else if (is_sep) begin
               act_end = 1'b1;
            end else begin
               state_mid = STATE_AFTER;
            end
         end
         STATE_AFTER: begin
            if (is_sep) act_end = 1'b1;
         end
         default: begin
            if (is_sep) begin
               act_end = 1'b1;
            end else if (is_quo) begin
               state_mid = STATE_QUO;
            end else begin
               act_byte  = 1'b1;
               state_mid = STATE_UNQ;
            end
         end
      endcase
      col_mid = col_ff;
      if (act_end) begin
         state_mid = STATE_START;
         if (col_ff < csvt_pkg::COL_CAP) col_mid = col_ff + 1'b1;
      end
   end

   always_comb begin
      act_res.out_byte    = act_byte ? req_in_byte : '0;
      act_res.byte_valid  = act_byte;
      act_res.field_index = col_ff;
      act_res.field_end   = act_end;
      act_res.record_end  = 1'b0;
      act_res.quote_error = 1'b0;

      line_res.out_byte    = '0;
      line_res.byte_valid  = 1'b0;
      line_res.field_index = col_mid;
      line_res.field_end   = 1'b1;
      line_res.record_end  = 1'b1;
      line_res.quote_error = (state_mid == STATE_QUO);

      q_entry.r0  = (act_byte || act_end) ? act_res : line_res;
      q_entry.r1  = line_res;
      q_entry.two = (act_byte || act_end) && req_line_last;
   end

   assign q_push = accept && (act_byte || act_end || req_line_last);

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      if (accept) begin
         state_in = req_line_last ? STATE_START : state_mid;
         col_in   = req_line_last ? '0 : col_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff   <= csvt_pkg::SEP_RESET;
         quote_ff <= csvt_pkg::QUOTE_RESET;
         state_ff <= STATE_START;
         col_ff   <= '0;
      end else begin
         sep_ff   <= sep_in;
         quote_ff <= quote_in;
         state_ff <= state_in;
         col_ff   <= col_in;
      end
   end

endmodule

>>> design/csvt_queue.sv
module csvt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvt_pkg::entry_type push_entry,
   input  logic                pop,
   output csvt_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   csvt_pkg::entry_type              mem_ff [csvt_pkg::QDEPTH];
   logic [csvt_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [csvt_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [csvt_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   localparam logic [csvt_pkg::QPTR_W-1:0] PTR_LAST =
      csvt_pkg::QPTR_W'(csvt_pkg::QDEPTH - 1);

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == csvt_pkg::QCNT_W'(csvt_pkg::QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> design/csvt_back.sv
module csvt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  csvt_pkg::entry_type         head,
   input  logic                        empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [csvt_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic [csvt_pkg::COL_W-1:0]  rsp_field_index,
   output logic                        rsp_field_end,
   output logic                        rsp_record_end,
   output logic                        rsp_quote_error,
   output logic                        rsp_run_last
);

   logic                 sel_ff, sel_in;
   logic                 xfer;
   csvt_pkg::result_type res;

   assign rsp_valid       = !empty;
   assign res             = sel_ff ? head.r1 : head.r0;
   assign rsp_out_byte    = res.out_byte;
   assign rsp_byte_valid  = res.byte_valid;
   assign rsp_field_index = res.field_index;
   assign rsp_field_end   = res.field_end;
   assign rsp_record_end  = res.record_end;
   assign rsp_quote_error = res.quote_error;
   assign rsp_run_last    = sel_ff || !head.two;

   assign xfer   = rsp_valid && rsp_ready;
   assign pop    = xfer && rsp_run_last;
   assign sel_in = xfer ? !rsp_run_last : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

>>> design/csv_field_tokenizer.sv
// Streaming CSV field splitter: one byte per transfer on req_, tagged with
// req_line_last on the final byte of a line; rsp_ gives field content bytes,
// field ends and record ends with the saturating column index. Quoting follows
// RFC 4180 with programmable separator (csr index 0) and quote (csr index 1).
// A byte is taken every cycle while the queue is not full; its results are
// registered in the queue. A byte that gives two results (content or field
// end followed by the record end of the line) holds the single result port
// for both, and the two-entry queue between parser and output sequencer may
// then push back on req_ready. Write CSRs only while idle.
module csv_field_tokenizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [csvt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csvt_pkg::BYTE_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [csvt_pkg::BYTE_W-1:0]     req_in_byte,
   input  logic                            req_line_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [csvt_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic [csvt_pkg::COL_W-1:0]      rsp_field_index,
   output logic                            rsp_field_end,
   output logic                            rsp_record_end,
   output logic                            rsp_quote_error,
   output logic                            rsp_run_last
);

   logic                q_push, q_pop, q_empty, q_full;
   csvt_pkg::entry_type q_entry, q_head;

   csvt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_line_last (req_line_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   csvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   csvt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .empty           (q_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_field_index (rsp_field_index),
      .rsp_field_end   (rsp_field_end),
      .rsp_record_end  (rsp_record_end),
      .rsp_quote_error (rsp_quote_error),
      .rsp_run_last    (rsp_run_last)
   );

`ifndef SYNTHESIS
   a_rec_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_end |-> rsp_field_end && rsp_run_last)
      else $error("record end without field end or run end");

   a_qerr_on_rec_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quote_error |-> rsp_record_end)
      else $error("quote error outside record end");

   a_byte_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_field_end)
      else $error("content byte marked as field end");

   a_second_is_rec_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid && rsp_record_end)
      else $error("second result of a byte is not a record end");
`endif

endmodule

>>> test/csv_field_tokenizer_chk.sv
module csv_field_tokenizer_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  csvt_pkg::csr_idx_type         csr_index,
   input  logic [csvt_pkg::BYTE_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [csvt_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic                          req_line_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [csvt_pkg::BYTE_W-1:0]   rsp_out_byte,
   input  logic                          rsp_byte_valid,
   input  logic [csvt_pkg::COL_W-1:0]    rsp_field_index,
   input  logic                          rsp_field_end,
   input  logic                          rsp_record_end,
   input  logic                          rsp_quote_error,
   input  logic                          rsp_run_last,
   output int                            errors,
   output int                            pending
);

   typedef enum logic [5:0] {
      PS_START   = 6'b000001,
      PS_UNQ     = 6'b000010,
      PS_UNQ_Q   = 6'b000100,
      PS_QUO     = 6'b001000,
      PS_QUO_Q   = 6'b010000,
      PS_AFTER   = 6'b100000
   } parse_state_type;

   typedef struct packed {
      csvt_pkg::result_type res;
      logic                 run_last;
   } field_token_type;

   logic [csvt_pkg::BYTE_W-1:0] sep_char   = csvt_pkg::SEP_RESET;
   logic [csvt_pkg::BYTE_W-1:0] quote_char = csvt_pkg::QUOTE_RESET;
   parse_state_type             pstate     = PS_START;
   logic [csvt_pkg::COL_W-1:0]  column     = '0;
   field_token_type             expected_tokens[$];
   int                          fail_count = 0;
   int                          pending_count = 0;

   assign errors  = fail_count;
   assign pending = pending_count;

   function automatic field_token_type make_token(logic [csvt_pkg::BYTE_W-1:0] b,
                                                  logic valid, logic fe,
                                                  logic re, logic err);
      field_token_type t;
      t.res.out_byte    = valid ? b : '0;
      t.res.byte_valid  = valid;
      t.res.field_index = column;
      t.res.field_end   = fe;
      t.res.record_end  = re;
      t.res.quote_error = err;
      t.run_last        = 1'b0;
      return t;
   endfunction

   task automatic tokenize_byte(input logic [csvt_pkg::BYTE_W-1:0] b, input logic last);
      logic            is_sep;
      logic            is_quo;
      logic            emit_byte;
      logic            emit_end;
      field_token_type toks[2];
      int              n;
      is_sep    = (b == sep_char);
      is_quo    = (b == quote_char) && !is_sep;
      emit_byte = 1'b0;
      emit_end  = 1'b0;
      n         = 0;
      case (pstate)
         PS_UNQ: begin
            if (is_sep) emit_end = 1'b1;
            else begin
               emit_byte = 1'b1;
               if (is_quo) pstate = PS_UNQ_Q;
            end
         end
         PS_UNQ_Q: begin
            if (is_sep) emit_end = 1'b1;
            else if (is_quo) pstate = PS_UNQ;
            else begin
               emit_byte = 1'b1;
               pstate    = PS_UNQ;
            end
         end
         PS_QUO: begin
            if (is_quo) pstate = PS_QUO_Q;
            else emit_byte = 1'b1;
         end
         PS_QUO_Q: begin
            if (is_quo) begin
               emit_byte = 1'b1;
               pstate    = PS_QUO;
            end else if (is_sep) emit_end = 1'b1;
            else pstate = PS_AFTER;
         end
         PS_AFTER: begin
            if (is_sep) emit_end = 1'b1;
         end
         default: begin
            if (is_sep) emit_end = 1'b1;
            else if (is_quo) pstate = PS_QUO;
            else begin
               emit_byte = 1'b1;
               pstate    = PS_UNQ;
            end
         end
      endcase
      if (emit_byte) begin
         toks[n] = make_token(b, 1'b1, 1'b0, 1'b0, 1'b0);
         n++;
      end else if (emit_end) begin
         toks[n] = make_token(b, 1'b0, 1'b1, 1'b0, 1'b0);
         n++;
         if (column < csvt_pkg::COL_CAP) column = column + 1'b1;
         pstate = PS_START;
      end
      if (last) begin
         toks[n] = make_token(b, 1'b0, 1'b1, 1'b1, pstate == PS_QUO);
         n++;
         pstate = PS_START;
         column = '0;
      end
      if (n > 0) toks[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens = {expected_tokens, toks[i]};
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      field_token_type tok;
      if (reset) begin
         sep_char   = csvt_pkg::SEP_RESET;
         quote_char = csvt_pkg::QUOTE_RESET;
         pstate     = PS_START;
         column     = '0;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected transfer: out_byte %0d field_index %0d field_end %0d",
                      rsp_out_byte, rsp_field_index, rsp_field_end);
               fail_count++;
            end else begin
               tok = expected_tokens.pop_front();
               check_field("out_byte", tok.res.out_byte, rsp_out_byte);
               check_field("byte_valid", tok.res.byte_valid, rsp_byte_valid);
               check_field("field_index", tok.res.field_index, rsp_field_index);
               check_field("field_end", tok.res.field_end, rsp_field_end);
               check_field("record_end", tok.res.record_end, rsp_record_end);
               check_field("quote_error", tok.res.quote_error, rsp_quote_error);
               check_field("run_last", tok.run_last, rsp_run_last);
            end
         end
         if (csr_we) begin
            case (csr_index)
               csvt_pkg::CSR_SEP:   sep_char   = csr_wdata;
               csvt_pkg::CSR_QUOTE: quote_char = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) tokenize_byte(req_in_byte, req_line_last);
      end
      pending_count <= expected_tokens.size();
   end

endmodule

>>> test/csv_field_tokenizer_tb.sv
module csv_field_tokenizer_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 6;
   localparam int BLOCK_ITEMS = 110;

   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          csr_we          = 1'b0;
   csvt_pkg::csr_idx_type         csr_index       = csvt_pkg::CSR_SEP;
   logic [csvt_pkg::BYTE_W-1:0]   csr_wdata       = '0;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic [csvt_pkg::BYTE_W-1:0]   req_in_byte     = '0;
   logic                          req_line_last   = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [csvt_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic                          rsp_byte_valid;
   logic [csvt_pkg::COL_W-1:0]    rsp_field_index;
   logic                          rsp_field_end;
   logic                          rsp_record_end;
   logic                          rsp_quote_error;
   logic                          rsp_run_last;
   int                            fail_count;
   int                            pending;

   int                            snd_idle    = 19;
   int                            rcv_idle    = 50;
   int                            items_sent  = 0;
   int                            cycle_count = 0;
   logic [csvt_pkg::BYTE_W-1:0]   cur_sep     = csvt_pkg::SEP_RESET;
   logic [csvt_pkg::BYTE_W-1:0]   cur_quote   = csvt_pkg::QUOTE_RESET;
   logic [csvt_pkg::BYTE_W-1:0]   line_buf[$];

   logic [csvt_pkg::BYTE_W-1:0]   sep_tab[5]   = '{8'd0, 8'd255, 8'd59, 8'd44, 8'd9};
   logic [csvt_pkg::BYTE_W-1:0]   quote_tab[5] = '{8'd255, 8'd0, 8'd59, 8'd34, 8'd39};

   csv_field_tokenizer dut (.*);

   csv_field_tokenizer_chk checker_i (.*, .errors(fail_count), .pending(pending));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic put_byte(input logic [csvt_pkg::BYTE_W-1:0] b, input bit last);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_line_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_chars(input logic [csvt_pkg::BYTE_W-1:0] sep,
                            input logic [csvt_pkg::BYTE_W-1:0] quo);
      csr_we    <= 1'b1;
      csr_index <= csvt_pkg::CSR_SEP;
      csr_wdata <= sep;
      @(posedge clock);
      csr_index <= csvt_pkg::CSR_QUOTE;
      csr_wdata <= quo;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_sep   = sep;
      cur_quote = quo;
   endtask

   function automatic logic [csvt_pkg::BYTE_W-1:0] plain_byte();
      logic [csvt_pkg::BYTE_W-1:0] b;
      do b = csvt_pkg::BYTE_W'($urandom_range(255)); while (b == cur_sep || b == cur_quote);
      return b;
   endfunction

   function automatic void append_byte(input logic [csvt_pkg::BYTE_W-1:0] b);
      line_buf = {line_buf, b};
   endfunction

   task automatic send_line();
      int nfields;
      int kind;
      int len;
      int r;
      line_buf.delete();
      nfields = ($urandom_range(29) == 0) ? $urandom_range(33, 38) : $urandom_range(1, 5);
      for (int f = 0; f < nfields; f++) begin
         if (f != 0) append_byte(cur_sep);
         kind = (nfields > 20) ? $urandom_range(4) : $urandom_range(9);
         len  = $urandom_range(1, 5);
         case (kind)
            0: ;
            1, 2, 3, 4: begin
               append_byte(plain_byte());
               for (int i = 1; i < len; i++) begin
                  if ($urandom_range(5) == 0) begin
                     append_byte(cur_quote);
                     if ($urandom_range(1) == 1) append_byte(cur_quote);
                  end else append_byte(plain_byte());
               end
            end
            5, 6, 7, 8: begin
               append_byte(cur_quote);
               for (int i = 0; i < len; i++) begin
                  r = $urandom_range(5);
                  if (r == 0) append_byte(cur_sep);
                  else if (r == 1) begin
                     append_byte(cur_quote);
                     append_byte(cur_quote);
                  end else append_byte(plain_byte());
               end
               // unterminated quote only on the line's last field
               if (!(kind == 8 && f == nfields - 1)) begin
                  append_byte(cur_quote);
                  if ($urandom_range(3) == 0)
                     repeat ($urandom_range(1, 3)) append_byte(plain_byte());
               end
            end
            default: repeat (len) append_byte(csvt_pkg::BYTE_W'($urandom_range(255)));
         endcase
      end
      if ($urandom_range(7) == 0 || line_buf.size() == 0) append_byte(cur_sep);
      foreach (line_buf[i]) put_byte(line_buf[i], i == line_buf.size() - 1);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // leading and doubled separator
      put_byte(",", 1'b0);
      put_byte(",", 1'b0);
      put_byte("a", 1'b1);
      // quoted field with separator, doubled quote, trailing junk, separator last
      put_byte("\"", 1'b0);
      put_byte("x", 1'b0);
      put_byte(",", 1'b0);
      put_byte("\"", 1'b0);
      put_byte("\"", 1'b0);
      put_byte("y", 1'b0);
      put_byte("\"", 1'b0);
      put_byte("q", 1'b0);
      put_byte(",", 1'b1);
      // doubled quote inside unquoted field
      put_byte("a", 1'b0);
      put_byte("\"", 1'b0);
      put_byte("\"", 1'b0);
      put_byte("b", 1'b1);
      // open quote at line end
      put_byte("\"", 1'b0);
      put_byte("k", 1'b1);
      put_byte("\"", 1'b1);
      // byte extremes
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b1);

      for (int b = 0; b < 5; b++) begin
         drain();
         set_chars(sep_tab[b], quote_tab[b]);
         snd_idle = (b < 2) ? 19 : (b < 4) ? 50 : 0;
         rcv_idle = (b < 2) ? 50 : (b < 4) ? 19 : 0;
         while (items_sent < 21 + BLOCK_ITEMS * (b + 1)) begin
            if ($urandom_range(7) == 0)
               repeat ($urandom_range(1, 8))
                  put_byte(csvt_pkg::BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
            else send_line();
         end
      end
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
